// ----- rtl/rfmc_pkg.sv -----
// shared types and constants for the follow-mode controller
package rfmc_pkg;

    localparam int DVD_W = 30;   // dividend and quotient width of the shared divider
    localparam int DVS_W = 16;   // divisor width of the shared divider

    // register indexes of the configuration port
    localparam logic [2:0] REG_FOLLOW_DISTANCE = 3'd0;
    localparam logic [2:0] REG_SAFE_DISTANCE   = 3'd1;
    localparam logic [2:0] REG_MAX_LINEAR      = 3'd2;
    localparam logic [2:0] REG_MAX_ANGULAR     = 3'd3;
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd4;

    // 0.1 m in q8.8, rounded
    localparam logic [15:0] MIN_FRONT = 16'd26;

    localparam logic [23:0] ANG_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] ANG_NEG_MIN = 24'h800000;

    typedef enum logic [2:0] {
        MODE_SEARCH_FACE   = 3'd0,
        MODE_FOLLOW_FACE   = 3'd1,
        MODE_SEARCH_MARKER = 3'd2,
        MODE_FOLLOW_MARKER = 3'd3,
        MODE_AVOID         = 3'd4
    } mode_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

// ----- rtl/rfmc_if.sv -----
// item channels of the follow-mode controller
interface rfmc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] front_distance;
    logic [15:0] front_left_distance;
    logic [15:0] front_right_distance;
    logic        vision_new;
    logic        marker_found;
    logic [11:0] face_left;
    logic [11:0] face_width;
    logic [11:0] marker_center_x;

    modport source (
        output valid, front_distance, front_left_distance, front_right_distance,
               vision_new, marker_found, face_left, face_width, marker_center_x,
        input  ready
    );
    modport sink (
        input  valid, front_distance, front_left_distance, front_right_distance,
               vision_new, marker_found, face_left, face_width, marker_center_x,
        output ready
    );
endinterface

interface rfmc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [15:0]        linear_speed;
    logic signed [23:0] angular_speed;

    modport source (
        output valid, mode, linear_speed, angular_speed,
        input  ready
    );
    modport sink (
        input  valid, mode, linear_speed, angular_speed,
        output ready
    );
endinterface

// ----- rtl/rfmc_div.sv -----
// restoring divider, one quotient bit per cycle
module rfmc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rfmc_pkg::div_req_t         req,
    output logic                       done,
    output logic [rfmc_pkg::DVD_W-1:0] quotient
);
    import rfmc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/robot_follow_mode_controller.sv -----
// top level of the robot follow-mode controller
// Each input item is one control tick: three front range readings in q8.8 metres and, when
// vision_new is set, a fresh vision result that is held together with a sticky seen flag.
// The controller steps its five-mode machine once per item and returns one item with the
// mode, a linear speed clamped to max_linear and a proportional angular speed in q12.12,
// saturated to 24 bits signed. Items are handled one at a time: avoid and search ticks skip
// the divider, face follow ticks make two passes and marker follow ticks one or two passes
// through the shared 30-bit restoring divider at one quotient bit per cycle (steering,
// then speed unless the gap alone decides it). A finished result sits in the output
// register, so the next item is taken while it waits. The five registers are to be written
// through cfg_we/cfg_index/cfg_wdata by the user only while the block is idle; the block does
// not enforce it. Unknown indexes are ignored and a zero frame width steers as a width of one.
module robot_follow_mode_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    rfmc_in_if.sink     in_ch,
    rfmc_out_if.source  out_ch
);
    import rfmc_pkg::*;

    // sequencer, one-hot
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MODE     = 8'b0000_0010,
        S_MUL      = 8'b0000_0100,
        S_ANG_GO   = 8'b0000_1000,
        S_ANG_WAIT = 8'b0001_0000,
        S_LIN_GO   = 8'b0010_0000,
        S_LIN_WAIT = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] follow_reg, safe_reg, max_lin_reg, max_ang_reg;
    logic [11:0] frame_w_reg;

    // held vision and mode
    mode_t       mode_reg, mode_next;
    logic        seen_reg, seen_next;
    logic        mfound_reg, mfound_next;
    logic [11:0] face_left_reg, face_left_next;
    logic [11:0] face_w_reg, face_w_next;
    logic [11:0] marker_x_reg, marker_x_next;

    // per-item working registers
    logic [15:0]      front_reg, front_next;
    logic             left_wins_reg, left_wins_next;
    logic [DVD_W-1:0] prod_reg, prod_next;
    logic             neg_reg, neg_next;
    logic [15:0]      lin_reg, lin_next;
    logic [23:0]      ang_reg, ang_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_mode_reg, out_mode_next;
    logic [15:0] out_lin_reg, out_lin_next;
    logic [23:0] out_ang_reg, out_ang_next;

    // shared divider
    div_req_t         div_req;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    logic [11:0]        frame_w_eff;
    logic signed [14:0] err;
    logic [14:0]        err_abs;
    logic               tracking;
    logic [15:0]        front_den;
    logic [15:0]        gap;
    logic [23:0]        ang_sat;
    logic [15:0]        lin_clamp;

    rfmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ch.ready = (state_reg == S_IDLE);

    // steering error in half pixels: face uses box centre doubled, marker its x doubled
    always_comb
    begin
        frame_w_eff = (frame_w_reg == '0) ? 12'd1 : frame_w_reg;
        if (mode_reg == MODE_FOLLOW_FACE)
            err = $signed({2'b00, face_left_reg, 1'b0}) + $signed({3'b000, face_w_reg})
                - $signed({3'b000, frame_w_reg});
        else
            err = $signed({2'b00, marker_x_reg, 1'b0}) - $signed({3'b000, frame_w_reg});
        err_abs   = err[14] ? (15'd0 - err) : err;
        tracking  = seen_reg && mfound_reg;
        front_den = (front_reg > MIN_FRONT) ? front_reg : MIN_FRONT;
        gap       = front_reg - follow_reg;

        // turn rate is -(err * max_angular) / width, truncated toward zero, then saturated
        if (neg_reg)
            ang_sat = (div_q > DVD_W'(ANG_NEG_MIN)) ? ANG_NEG_MIN : (24'd0 - div_q[23:0]);
        else
            ang_sat = (div_q > DVD_W'(ANG_POS_MAX)) ? ANG_POS_MAX : div_q[23:0];

        lin_clamp = (div_q > DVD_W'(max_lin_reg)) ? max_lin_reg : div_q[15:0];
    end

    // divider request, muxed by sequencer step
    always_comb
    begin
        div_req.start    = (state_reg == S_ANG_GO) || (state_reg == S_LIN_GO);
        div_req.dividend = prod_reg;
        div_req.divisor  = DVS_W'(frame_w_eff);
        if (state_reg == S_LIN_GO)
        begin
            if (mode_reg == MODE_FOLLOW_FACE)
            begin
                div_req.dividend = DVD_W'({follow_reg, 12'd0});
                div_req.divisor  = front_den;
            end
            else
            begin
                div_req.dividend = DVD_W'({gap, 12'd0});
                div_req.divisor  = follow_reg;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        seen_next      = seen_reg;
        mfound_next    = mfound_reg;
        face_left_next = face_left_reg;
        face_w_next    = face_w_reg;
        marker_x_next  = marker_x_reg;
        front_next     = front_reg;
        left_wins_next = left_wins_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        lin_next       = lin_reg;
        ang_next       = ang_reg;
        out_valid_next = out_valid_reg;
        out_mode_next  = out_mode_reg;
        out_lin_next   = out_lin_reg;
        out_ang_next   = out_ang_reg;

        if (out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    front_next     = in_ch.front_distance;
                    left_wins_next = in_ch.front_left_distance > in_ch.front_right_distance;
                    if (in_ch.vision_new)
                    begin
                        seen_next      = 1'b1;
                        mfound_next    = in_ch.marker_found;
                        face_left_next = in_ch.face_left;
                        face_w_next    = in_ch.face_width;
                        marker_x_next  = in_ch.marker_center_x;
                    end
                    state_next = S_MODE;
                end
            end

            S_MODE:
            begin
                // transition priority: obstacle first, then leave avoid, then vision
                priority if (front_reg < safe_reg)
                    mode_next = MODE_AVOID;
                else if (mode_reg == MODE_AVOID)
                    mode_next = MODE_SEARCH_FACE;
                else if (mode_reg == MODE_SEARCH_FACE && seen_reg)
                    mode_next = MODE_FOLLOW_FACE;
                else if (mode_reg == MODE_FOLLOW_FACE && tracking)
                    mode_next = MODE_FOLLOW_MARKER;
                else if (mode_reg == MODE_FOLLOW_MARKER && !tracking)
                    mode_next = MODE_SEARCH_MARKER;
                else if (mode_reg == MODE_SEARCH_MARKER && tracking)
                    mode_next = MODE_FOLLOW_MARKER;
                else
                    mode_next = mode_reg;

                lin_next = '0;
                if (mode_next == MODE_AVOID)
                begin
                    ang_next   = left_wins_reg ? {8'd0, max_ang_reg}
                                               : (24'd0 - {8'd0, max_ang_reg});
                    state_next = S_DONE;
                end
                else if (mode_next == MODE_FOLLOW_FACE || mode_next == MODE_FOLLOW_MARKER)
                    state_next = S_MUL;
                else
                begin
                    // searching: turn in place at half rate
                    ang_next   = {9'd0, max_ang_reg[15:1]};
                    state_next = S_DONE;
                end
            end

            S_MUL:
            begin
                prod_next  = DVD_W'(err_abs[13:0]) * DVD_W'(max_ang_reg);
                neg_next   = !err[14] && (err != '0);
                state_next = S_ANG_GO;
            end

            S_ANG_GO:
                state_next = S_ANG_WAIT;

            S_ANG_WAIT:
            begin
                if (div_done)
                begin
                    ang_next = ang_sat;
                    if (mode_reg == MODE_FOLLOW_FACE)
                        state_next = S_LIN_GO;
                    else if (front_reg <= follow_reg)
                    begin
                        lin_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (follow_reg == '0)
                    begin
                        // zero target distance: full speed while any gap remains
                        lin_next   = max_lin_reg;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_LIN_GO;
                end
            end

            S_LIN_GO:
                state_next = S_LIN_WAIT;

            S_LIN_WAIT:
            begin
                if (div_done)
                begin
                    lin_next   = lin_clamp;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mode_next  = mode_reg;
                    out_lin_next   = lin_reg;
                    out_ang_next   = ang_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_reg  <= 16'd256;
            safe_reg    <= 16'd128;
            max_lin_reg <= 16'd2048;
            max_ang_reg <= 16'd4096;
            frame_w_reg <= 12'd640;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOLLOW_DISTANCE: follow_reg  <= cfg_wdata;
                REG_SAFE_DISTANCE:   safe_reg    <= cfg_wdata;
                REG_MAX_LINEAR:      max_lin_reg <= cfg_wdata;
                REG_MAX_ANGULAR:     max_ang_reg <= cfg_wdata;
                REG_FRAME_WIDTH:     frame_w_reg <= cfg_wdata[11:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_SEARCH_FACE;
            seen_reg      <= 1'b0;
            mfound_reg    <= 1'b0;
            face_left_reg <= '0;
            face_w_reg    <= '0;
            marker_x_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            seen_reg      <= seen_next;
            mfound_reg    <= mfound_next;
            face_left_reg <= face_left_next;
            face_w_reg    <= face_w_next;
            marker_x_reg  <= marker_x_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg     <= front_next;
        left_wins_reg <= left_wins_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        lin_reg       <= lin_next;
        ang_reg       <= ang_next;
        out_mode_reg  <= out_mode_next;
        out_lin_reg   <= out_lin_next;
        out_ang_reg   <= out_ang_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.mode          = out_mode_reg;
    assign out_ch.linear_speed  = out_lin_reg;
    assign out_ch.angular_speed = out_ang_reg;

endmodule

// ----- rtl/rfmc_check.sv -----
// port-level assertions for the follow-mode controller, bound to the top level
module rfmc_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_mode,
    input logic [15:0] out_linear
);
    import rfmc_pkg::*;

    // one item at a time: taking an item closes the input until it is done
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item in work");

    // avoid mode never drives forward
    a_avoid_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_mode == MODE_AVOID) |-> (out_linear == '0))
        else $error("forward speed commanded in avoid mode");

    // searching turns in place
    a_search_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_mode == MODE_SEARCH_FACE) || (out_mode == MODE_SEARCH_MARKER))
        |-> (out_linear == '0))
        else $error("forward speed commanded while searching");

    // a pending result is held until taken
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_linear))
        else $error("result dropped or changed while stalled");

endmodule

bind robot_follow_mode_controller rfmc_check u_rfmc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_mode   (out_ch.mode),
    .out_linear (out_ch.linear_speed)
);

// ----- dv/robot_follow_mode_controller_tb.sv -----
// self-checking testbench for the robot follow-mode controller
`timescale 1ns / 1ps

module robot_follow_mode_controller_tb;
    import rfmc_pkg::*;

    // run shape
    localparam int ITEMS_PER_PHASE = 270;
    localparam int PHASE_COUNT     = 6;
    localparam int HOLD_CYCLES     = 600;      // long receiver hold-off in the pressure phase
    localparam int DRAIN_CYCLES    = 80;       // a little over one follow tick
    localparam int CYCLE_LIMIT     = 1000000;

    // turn rate saturation bounds
    localparam longint RATE_TOP    = 64'sd8388607;
    localparam longint RATE_BOTTOM = -64'sd8388608;

    // one control tick as offered to the block
    typedef struct packed {
        logic [15:0] front;
        logic [15:0] left_range;
        logic [15:0] right_range;
        logic        vision_new;
        logic        marker_found;
        logic [11:0] face_left;
        logic [11:0] face_width;
        logic [11:0] marker_x;
    } tick_t;

    // one motion command as returned by the block
    typedef struct packed {
        mode_t       mode;
        logic [15:0] lin;
        logic [23:0] ang;
    } cmd_t;

    // clock and reset, known from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // configuration port
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // channel drive registers
    logic  drv_valid = 1'b0;
    tick_t drv_tick  = '0;
    logic  rx_ready  = 1'b0;
    logic  rx_hold   = 1'b0;
    logic  hold_go   = 1'b0;

    // idling knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    int cycle_count = 0;
    int fail_count  = 0;

    tick_t pending_ticks[$];
    cmd_t  expected_cmds[$];

    // predictor copy of the registers, reset values
    logic [15:0] follow_dist = 16'd256;
    logic [15:0] safe_dist   = 16'd128;
    logic [15:0] max_lin     = 16'd2048;
    logic [15:0] max_ang     = 16'd4096;
    logic [11:0] frame_w     = 12'd640;

    // predictor copy of the mode machine and held vision result
    mode_t       ctl_mode    = MODE_SEARCH_FACE;
    logic        seen_vision = 1'b0;
    logic        held_found  = 1'b0;
    logic [11:0] held_left   = '0;
    logic [11:0] held_width  = '0;
    logic [11:0] held_mx     = '0;

    rfmc_in_if  in_ch ();
    rfmc_out_if out_ch ();

    assign in_ch.valid                = drv_valid;
    assign in_ch.front_distance       = drv_tick.front;
    assign in_ch.front_left_distance  = drv_tick.left_range;
    assign in_ch.front_right_distance = drv_tick.right_range;
    assign in_ch.vision_new           = drv_tick.vision_new;
    assign in_ch.marker_found         = drv_tick.marker_found;
    assign in_ch.face_left            = drv_tick.face_left;
    assign in_ch.face_width           = drv_tick.face_width;
    assign in_ch.marker_center_x      = drv_tick.marker_x;
    assign out_ch.ready               = rx_ready;

    robot_follow_mode_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // proportional steering: error in half pixels scaled by max_ang over the frame width,
    // truncated toward zero, then saturated to 24 bits
    function automatic longint steer_rate(input longint err);
        longint width;
        longint rate;
        width = (frame_w == 12'd0) ? 64'sd1 : longint'(frame_w);
        rate  = -(err * longint'(max_ang)) / width;
        if (rate > RATE_TOP)
            rate = RATE_TOP;
        else if (rate < RATE_BOTTOM)
            rate = RATE_BOTTOM;
        return rate;
    endfunction

    // step the mode machine for one accepted tick and queue the command it produces
    task automatic predict_command(input tick_t t);
        cmd_t   c;
        longint rate;
        longint speed;
        longint den;
        // latch vision first, the transition sees the fresh result
        if (t.vision_new)
        begin
            held_found  = t.marker_found;
            held_left   = t.face_left;
            held_width  = t.face_width;
            held_mx     = t.marker_x;
            seen_vision = 1'b1;
        end
        // obstacle check wins over everything else
        if (t.front < safe_dist)
            ctl_mode = MODE_AVOID;
        else if (ctl_mode == MODE_AVOID)
            ctl_mode = MODE_SEARCH_FACE;
        else if (ctl_mode == MODE_SEARCH_FACE && seen_vision)
            ctl_mode = MODE_FOLLOW_FACE;
        else if ((ctl_mode == MODE_FOLLOW_FACE || ctl_mode == MODE_SEARCH_MARKER)
                 && seen_vision && held_found)
            ctl_mode = MODE_FOLLOW_MARKER;
        else if (ctl_mode == MODE_FOLLOW_MARKER && !(seen_vision && held_found))
            ctl_mode = MODE_SEARCH_MARKER;

        rate  = 0;
        speed = 0;
        case (ctl_mode)
            MODE_AVOID:
                rate = (t.left_range > t.right_range) ? longint'(max_ang)
                                                      : -longint'(max_ang);
            MODE_FOLLOW_FACE:
            begin
                // face centre error: left edge doubled plus width, against the frame
                rate  = steer_rate(2 * longint'(held_left) + longint'(held_width)
                                   - longint'(frame_w));
                // closer target means faster, front floored at 0.1 m
                den   = (t.front > MIN_FRONT) ? longint'(t.front) : longint'(MIN_FRONT);
                speed = (longint'(follow_dist) << 12) / den;
            end
            MODE_FOLLOW_MARKER:
            begin
                rate = steer_rate(2 * longint'(held_mx) - longint'(frame_w));
                // speed grows with the gap beyond the follow distance
                if (t.front > follow_dist)
                begin
                    if (follow_dist == 16'd0)
                        speed = longint'(max_lin);
                    else
                        speed = (longint'(16'(t.front - follow_dist)) << 12)
                                / longint'(follow_dist);
                end
            end
            default:
                rate = longint'(max_ang >> 1);
        endcase
        if (speed > longint'(max_lin))
            speed = longint'(max_lin);

        c.mode = ctl_mode;
        c.lin  = speed[15:0];
        c.ang  = rate[23:0];
        expected_cmds.push_back(c);
    endtask

    // pixel coordinate: mostly inside the frame, with extremes and full-range values
    function automatic logic [11:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 12'd0;
        else if (pick < 20)
            return 12'hFFF;
        else if (pick < 45)
            return 12'($urandom_range(4095));
        else
            return 12'($urandom_range(frame_w));
    endfunction

    // random tick shaped around the current thresholds so the machine gets past avoid
    function automatic tick_t random_tick();
        tick_t       t;
        int unsigned pick;
        int unsigned near_hi;
        pick    = $urandom_range(99);
        near_hi = 2 * follow_dist + 300;
        if (near_hi > 65535)
            near_hi = 65535;
        if (pick < 8 && safe_dist != 16'd0)
            t.front = 16'($urandom_range(safe_dist - 1, 0));
        else if (pick < 16)
        begin
            case ($urandom_range(3))
                0:       t.front = 16'h0000;
                1:       t.front = 16'hFFFF;
                2:       t.front = follow_dist;
                default: t.front = 16'(MIN_FRONT - 1 + $urandom_range(2));
            endcase
        end
        else if (pick < 55)
            t.front = 16'($urandom_range(65535, safe_dist));
        else
            t.front = 16'($urandom_range(near_hi, safe_dist));

        t.left_range  = 16'($urandom_range(65535));
        t.right_range = ($urandom_range(4) == 0) ? t.left_range
                                                 : 16'($urandom_range(65535));
        t.vision_new   = ($urandom_range(3) == 0);
        t.marker_found = 1'($urandom_range(1));
        t.face_left    = random_pixel();
        t.face_width   = random_pixel();
        t.marker_x     = random_pixel();
        return t;
    endfunction

    // directed tick
    task automatic queue_tick(input logic [15:0] front, input logic [15:0] fl,
                              input logic [15:0] fr, input logic vnew, input logic mf,
                              input logic [11:0] face_l, input logic [11:0] face_w,
                              input logic [11:0] mx);
        tick_t t;
        t.front        = front;
        t.left_range   = fl;
        t.right_range  = fr;
        t.vision_new   = vnew;
        t.marker_found = mf;
        t.face_left    = face_l;
        t.face_width   = face_w;
        t.marker_x     = mx;
        pending_ticks.push_back(t);
    endtask

    // wait until every tick is accepted and every command is back, then let the block settle
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || drv_valid || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write per clock, predictor copy follows the same masking
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_FOLLOW_DISTANCE: follow_dist = data;
            REG_SAFE_DISTANCE:   safe_dist   = data;
            REG_MAX_LINEAR:      max_lin     = data;
            REG_MAX_ANGULAR:     max_ang     = data;
            REG_FRAME_WIDTH:     frame_w     = data[11:0];
            default: ;
        endcase
    endtask

    // full register set plus one write to an unused index
    task automatic apply_settings(input logic [15:0] fd, input logic [15:0] sd,
                                  input logic [15:0] ml, input logic [15:0] ma,
                                  input logic [15:0] fw_word);
        write_reg(REG_FOLLOW_DISTANCE, fd);
        write_reg(REG_SAFE_DISTANCE, sd);
        write_reg(REG_MAX_LINEAR, ml);
        write_reg(REG_MAX_ANGULAR, ma);
        write_reg(REG_FRAME_WIDTH, fw_word);
        write_reg(REG_FRAME_WIDTH + 3'($urandom_range(3, 1)), 16'($urandom_range(65535)));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random register values, each with a chance of landing on an extreme
    task automatic apply_random_settings();
        logic [15:0] fd;
        logic [15:0] sd;
        logic [15:0] ml;
        logic [15:0] ma;
        logic [15:0] fw_word;
        case ($urandom_range(7))
            0:       fd = 16'h0000;
            1:       fd = 16'hFFFF;
            default: fd = 16'($urandom_range(2048, 64));
        endcase
        case ($urandom_range(15))
            0:       sd = 16'h0000;
            1:       sd = 16'hFFFF;
            default: sd = 16'($urandom_range(512));
        endcase
        case ($urandom_range(7))
            0:       ml = 16'h0000;
            1:       ml = 16'hFFFF;
            default: ml = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(7))
            0:       ma = 16'h0000;
            1:       ma = 16'hFFFF;
            default: ma = 16'($urandom_range(65535));
        endcase
        // upper nibble is junk, only 12 bits land
        fw_word[15:12] = 4'($urandom_range(15));
        case ($urandom_range(9))
            0:       fw_word[11:0] = 12'd0;
            1:       fw_word[11:0] = 12'd1;
            2:       fw_word[11:0] = 12'hFFF;
            default: fw_word[11:0] = 12'($urandom_range(4095, 1));
        endcase
        apply_settings(fd, sd, ml, ma, fw_word);
    endtask

    // driver: predicts on acceptance, then offers the next queued tick or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (drv_valid && in_ch.ready)
                predict_command(drv_tick);
            if (!drv_valid || in_ch.ready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    drv_tick  <= pending_ticks.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted command with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t want;
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && rx_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected command: expected none, got mode %0d lin %0d ang %0d",
                             $time, out_ch.mode, out_ch.linear_speed, out_ch.angular_speed);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (out_ch.mode !== want.mode)
                    begin
                        fail_count++;
                        $display("%0t mode mismatch: expected %0d, got %0d",
                                 $time, want.mode, out_ch.mode);
                    end
                    if (out_ch.linear_speed !== want.lin)
                    begin
                        fail_count++;
                        $display("%0t linear_speed mismatch: expected %0d, got %0d",
                                 $time, want.lin, out_ch.linear_speed);
                    end
                    if (out_ch.angular_speed !== want.ang)
                    begin
                        fail_count++;
                        $display("%0t angular_speed mismatch: expected %0d, got %0d",
                                 $time, $signed(want.ang), out_ch.angular_speed);
                    end
                end
            end
            rx_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the block fills up and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: walk through every mode
        queue_tick(16'd1000, 16'd300, 16'd300, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        // avoid turning left, then right on a tie
        queue_tick(16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'd127, 16'd500, 16'd500, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        // exactly at the safe distance leaves avoid
        queue_tick(16'd128, 16'd0, 16'hFFFF, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        // first vision result, no marker: follow face
        queue_tick(16'd300, 16'd1, 16'd2, 1'b1, 1'b0, 12'd0, 12'd0, 12'hFFF);
        queue_tick(16'hFFFF, 16'd2, 16'd1, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        // marker found: follow marker, then gap zero and negative
        queue_tick(16'd512, 16'd0, 16'd0, 1'b1, 1'b1, 12'hFFF, 12'hFFF, 12'd0);
        queue_tick(16'd256, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'd200, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        // marker lost, then found again
        queue_tick(16'd1000, 16'd0, 16'd0, 1'b1, 1'b0, 12'd5, 12'd6, 12'd7);
        queue_tick(16'd1000, 16'd0, 16'd0, 1'b1, 1'b1, 12'd100, 12'd200, 12'hFFF);
        // obstacle, then back through search face and follow face to follow marker
        queue_tick(16'd0, 16'd10, 16'd20, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        wait_idle();

        // zero follow distance and turn rate saturation in follow marker
        apply_settings(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hF001);
        queue_tick(16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'd10, 16'd0, 16'd0, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0);
        wait_idle();

        // zero frame width steers as a width of one
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        queue_tick(16'd0, 16'd1, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
        queue_tick(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        wait_idle();

        // follow face with the front below the 0.1 m floor
        apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0FFF);
        queue_tick(16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'd25, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);
        queue_tick(16'd26, 16'd0, 16'd0, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0);

        // random phases, each with its own registers and idling
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_idle();
            apply_random_settings();
            case (ph)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                3:       begin tx_idle_pct = 36; rx_stall_pct = 36; end
                4:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_go = 1'b1; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 60; end
            endcase
            repeat (ITEMS_PER_PHASE) pending_ticks.push_back(random_tick());
        end
        wait_idle();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- robot_follow_mode_controller.f -----
rtl/rfmc_pkg.sv
rtl/rfmc_if.sv
rtl/rfmc_div.sv
rtl/robot_follow_mode_controller.sv
rtl/rfmc_check.sv
dv/robot_follow_mode_controller_tb.sv
